[src/fdc_pkg.sv]
// Package: shared types and constants for the focus distance calibration block.
`timescale 1ns / 1ps
`default_nettype none
package fdc_pkg;
   localparam int MaxPoints   = 16;
   localparam int ReadingBits = 12;
   localparam int IdxBits     = $clog2(MaxPoints);
   localparam int CntBits     = $clog2(MaxPoints + 1);
   localparam logic [15:0] InfinityCode = 16'hFFFF;
   localparam logic [6:0]  PctScale     = 7'd100;

   localparam logic [2:0] CSR_POINT_COUNT = 3'd0;
   localparam logic [2:0] CSR_DZ_NEAR     = 3'd1;
   localparam logic [2:0] CSR_DZ_FAR      = 3'd2;
   localparam logic [2:0] CSR_FAR_MARK    = 3'd3;
   localparam logic [2:0] CSR_INF_MARGIN  = 3'd4;
   localparam logic [2:0] CSR_FAR_ERR_PCT = 3'd5;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic        action;
      logic [3:0]  entry_index;
      logic [11:0] entry_reading;
      logic [15:0] entry_distance_cm;
      logic [11:0] reading;
   } req_type;

   typedef struct packed {
      logic        est_valid;
      logic        est_infinity;
      logic [15:0] distance_out_cm;
      logic        snap_found;
      logic [3:0]  snap_slot;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request
      logic wr_mark;   // write table entry
      logic est_step;  // one estimate scan step
      logic div_start;
      logic div_step;
      logic snap_step;
      logic rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_query;
      logic est_done;   // estimate settled (no divide needed or scan end)
      logic need_div;
      logic div_done;
      logic snap_done;
   } sts_type;
endpackage
`default_nettype wire

[src/fdc_ctrl.sv]
// Controller: sequences table write, estimate scan, divide and snap scan.
`timescale 1ns / 1ps
`default_nettype none
module fdc_ctrl
   import fdc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   typedef enum logic [2:0] {S_IDLE, S_DECODE, S_EST, S_DIVGO, S_DIV, S_SNAP, S_OUT}
      state_type;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // output slot frees when taken; a new item may start while a result waits
   wire slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            if (sts.is_query) state_in = S_EST;
            else begin
               cmd.wr_mark = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_EST: begin
            cmd.est_step = 1'b1;
            if (sts.est_done) state_in = sts.need_div ? S_DIVGO : S_SNAP;
         end
         S_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_SNAP;
         end
         S_SNAP: begin
            cmd.snap_step = 1'b1;
            if (sts.snap_done) state_in = S_OUT;
         end
         S_OUT: if (slot_free) begin
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

[src/fdc_datapath.sv]
// Datapath: mark table, config registers, scans, serial divider, result register.
`timescale 1ns / 1ps
`default_nettype none
module fdc_datapath
   import fdc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data,
   input  wire req_type     req_data,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output rsp_type          rsp_data
);
   localparam int RB = ReadingBits;
   localparam int NumW = 16 + 16 + RB;     // dl*dr*(rs-ls)
   localparam int DenW = 16 + RB + 1;      // dr*(rs-s)+dl*(s-ls)
   localparam int DivW = NumW + 2;         // 2*num+den
   localparam int CntW = $clog2(DivW + 1);

   // configuration
   logic [4:0]  cnt_ff;
   logic [11:0] dzn_ff, dzf_ff, infm_ff;
   logic [15:0] farm_ff;
   logic [6:0]  pct_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 5'd0;
         dzn_ff  <= 12'd5;
         dzf_ff  <= 12'd3;
         farm_ff <= 16'd500;
         infm_ff <= 12'd20;
         pct_ff  <= 7'd5;
      end else if (csr_write) begin
         case (csr_index)
            CSR_POINT_COUNT: cnt_ff  <= csr_data[4:0];
            CSR_DZ_NEAR:     dzn_ff  <= csr_data[11:0];
            CSR_DZ_FAR:      dzf_ff  <= csr_data[11:0];
            CSR_FAR_MARK:    farm_ff <= csr_data;
            CSR_INF_MARGIN:  infm_ff <= csr_data[11:0];
            CSR_FAR_ERR_PCT: pct_ff  <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   wire [CntBits-1:0] n_used = (cnt_ff > 5'(MaxPoints)) ? CntBits'(MaxPoints)
                                                        : CntBits'(cnt_ff);

   // request capture
   req_type req_ff;
   always_ff @(posedge clock) if (cmd.load) req_ff <= req_data;
   wire [RB-1:0] s = req_ff.reading;
   assign sts.is_query = (req_ff.action == ACT_QUERY);

   // mark table; unwritten entries are outside the contract
   logic [RB-1:0] mrd [MaxPoints];
   logic [15:0]   mds [MaxPoints];
   always_ff @(posedge clock) begin
      if (cmd.wr_mark) begin
         mrd[req_ff.entry_index] <= req_ff.entry_reading;
         mds[req_ff.entry_index] <= req_ff.entry_distance_cm;
      end
   end

   // estimate scan: step k visits mark k (exact match) and pair k-1,k (between)
   logic [CntBits-1:0] ei_ff;
   logic               e_valid_ff, e_inf_ff, e_hit_ff;
   logic [15:0]        e_cm_ff;
   logic [RB-1:0]      ls_ff, rs_ff;
   logic [15:0]        dl_ff, dr_ff;
   logic               b_found_ff;  // first between-pair seen
   logic               e_done;
   logic               need_div_ff;

   wire [IdxBits-1:0] ek   = ei_ff[IdxBits-1:0];
   wire [IdxBits-1:0] ekm1 = ek - 1'b1;
   wire [IdxBits-1:0] last_i = IdxBits'(n_used - 1'b1);
   wire [RB-1:0]       last_r = mrd[last_i];
   wire [RB:0]         lim = {1'b0, last_r} + (RB+1)'(infm_ff);
   wire                step_in = (ei_ff < n_used);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ei_ff       <= '0;
         e_valid_ff  <= 1'b0;
         e_inf_ff    <= 1'b0;
         e_hit_ff    <= 1'b0;
         e_cm_ff     <= '0;
         b_found_ff  <= 1'b0;
         need_div_ff <= 1'b0;
      end else if (cmd.est_step && !e_done) begin
         if (n_used == '0) begin
            e_hit_ff <= 1'b1;
         end else if (ei_ff == '0 && s < mrd[0]) begin
            e_hit_ff <= 1'b1; e_valid_ff <= 1'b1; e_cm_ff <= mds[0];
         end else if (ei_ff == '0 && {1'b0, s} > lim) begin
            e_hit_ff <= 1'b1; e_valid_ff <= 1'b1; e_inf_ff <= 1'b1;
            e_cm_ff  <= InfinityCode;
         end else if (step_in) begin
            if (s == mrd[ek]) begin
               e_hit_ff <= 1'b1; e_valid_ff <= 1'b1; e_cm_ff <= mds[ek];
            end else if (ei_ff != '0 && !b_found_ff && mrd[ekm1] < s && s < mrd[ek]) begin
               b_found_ff <= 1'b1;
               ls_ff <= mrd[ekm1]; rs_ff <= mrd[ek];
               dl_ff <= mds[ekm1]; dr_ff <= mds[ek];
            end
            ei_ff <= ei_ff + 1'b1;
         end else begin
            e_hit_ff <= 1'b1;
            if (b_found_ff) begin
               e_valid_ff <= 1'b1; need_div_ff <= 1'b1;
            end else if (s >= last_r) begin
               e_valid_ff <= 1'b1; e_cm_ff <= mds[last_i];
            end
         end
      end
   end
   assign e_done       = e_hit_ff;
   assign sts.est_done = e_hit_ff;
   assign sts.need_div = need_div_ff;

   // divide: sets up numerator/denominator with four multiplies over div_start and setup phase 0,
   // then restoring shift-subtract one bit per cycle
   logic [DivW-1:0] rem_ff, quo_ff;
   logic [DivW:0]   dsr_ff;
   logic [CntW-1:0] dc_ff;
   logic [1:0]      ph_ff;
   logic [31:0]     p1_ff;
   logic [DenW-1:0] den_ff;
   logic [NumW-1:0] num_ff;
   logic            dv_done_ff;

   wire [RB-1:0] span = rs_ff - ls_ff;
   wire [RB-1:0] rgap = rs_ff - s;
   wire [RB-1:0] lgap = s - ls_ff;
   // partial remainder with next dividend bit, and trial subtract of the divisor
   wire [DivW:0]   dv_sh = {rem_ff, quo_ff[DivW-1]};
   wire [DivW+1:0] trial = {1'b0, dv_sh} - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         ph_ff      <= 2'd0;
         dv_done_ff <= 1'b0;
         p1_ff      <= dl_ff * dr_ff;
         den_ff     <= DenW'(dr_ff * rgap);
      end else if (cmd.div_step && !dv_done_ff) begin
         case (ph_ff)
            2'd0: begin
               num_ff <= NumW'(p1_ff) * NumW'(span);
               den_ff <= den_ff + DenW'(dl_ff * lgap);
               ph_ff  <= 2'd1;
            end
            2'd1: begin
               quo_ff <= DivW'({num_ff, 1'b0}) + DivW'(den_ff);
               rem_ff <= '0;
               dsr_ff <= (DivW+1)'({den_ff, 1'b0});
               dc_ff  <= CntW'(DivW);
               ph_ff  <= 2'd2;
            end
            default: begin
               if (den_ff == '0) begin
                  quo_ff <= '0; dv_done_ff <= 1'b1;
               end else begin
                  // dividend shifts out of quo_ff as quotient bits shift in
                  if (dc_ff == '0) dv_done_ff <= 1'b1;
                  else begin
                     if (!trial[DivW+1]) begin
                        rem_ff <= trial[DivW-1:0];
                        quo_ff <= {quo_ff[DivW-2:0], 1'b1};
                     end else begin
                        rem_ff <= dv_sh[DivW-1:0];
                        quo_ff <= {quo_ff[DivW-2:0], 1'b0};
                     end
                     dc_ff <= dc_ff - 1'b1;
                  end
               end
            end
         endcase
      end
   end
   assign sts.div_done = dv_done_ff;
   wire [15:0] div_cm = (quo_ff > DivW'(16'hFFFF)) ? 16'hFFFF : quo_ff[15:0];
   wire [15:0] est_cm = need_div_ff ? div_cm : e_cm_ff;

   // snap scan, one mark per cycle
   logic [CntBits-1:0] si_ff;
   logic [12:0]        bd_ff;
   logic [IdxBits-1:0] bi_ff;
   logic               sf_ff;
   wire [IdxBits-1:0] sk = si_ff[IdxBits-1:0];
   wire [RB-1:0] mr = mrd[sk];
   wire [15:0]   md = mds[sk];
   wire [RB-1:0] dlt = (s > mr) ? s - mr : mr - s;
   wire          far = md >= farm_ff;
   wire [11:0]   dz  = far ? dzf_ff : dzn_ff;
   wire [15:0]   err = (est_cm > md) ? est_cm - md : md - est_cm;
   wire [22:0]   lhs = err * PctScale;
   wire [22:0]   rhs = md * pct_ff;
   wire reject = (dlt != '0) && far && e_valid_ff && !e_inf_ff && (lhs > rhs);
   assign sts.snap_done = !(si_ff < n_used);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         si_ff <= '0;
         sf_ff <= 1'b0;
         bi_ff <= '0;
      end else if (cmd.div_start || (cmd.est_step && e_done)) begin
         bd_ff <= ((dzn_ff > dzf_ff) ? {1'b0, dzn_ff} : {1'b0, dzf_ff}) + 13'd1;
      end else if (cmd.snap_step && !sts.snap_done) begin
         if ({1'b0, dlt} <= {1'b0, dz} && 13'(dlt) < bd_ff && !reject) begin
            bd_ff <= 13'(dlt);
            bi_ff <= sk;
            sf_ff <= 1'b1;
         end
         si_ff <= si_ff + 1'b1;
      end
   end

   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.est_valid       <= e_valid_ff;
         rsp_ff.est_infinity    <= e_valid_ff && e_inf_ff;
         rsp_ff.distance_out_cm <= e_valid_ff ? est_cm : 16'd0;
         rsp_ff.snap_found      <= sf_ff;
         rsp_ff.snap_slot       <= sf_ff ? 4'(bi_ff) : 4'd0;
      end
   end
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

[src/focus_distance_from_calibration_table_top.sv]
// Top level: calibration-table focus distance estimator.
// Sequence: a write item is captured, then written to the table at decode. A query with
//   interpolation runs decode, estimate scan, divide (start, setup phases, bit steps, finish),
//   snap scan and output; without interpolation the divide is skipped.
// Throughput: one item at a time; next request taken the cycle after the result loads.
// Reset (synchronous, active high) restores register defaults; the table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module focus_distance_from_calibration_table_top
   import fdc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   cmd_type cmd;
   sts_type sts;

   // sequencer
   fdc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
   );

   // table, scans, divider, result register
   fdc_datapath u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .req_data, .cmd, .sts,
      .rsp_data
   );
endmodule
`default_nettype wire

[src/fdc_checker.sv]
// Checker: port-level properties of the focus distance block, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module fdc_props
   import fdc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_inf_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.est_infinity |-> rsp_data.est_valid)
      else $error("infinity without valid estimate");
   a_nosnap_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.snap_found |-> rsp_data.snap_slot == '0)
      else $error("snap slot set without snap");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transfer taken while busy");
endmodule

bind focus_distance_from_calibration_table_top fdc_props u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
`default_nettype wire
